// ----- design/twt_pkg.sv -----
// ----------------------------------------------------------------------------
// Text window terminal package
// Shared types, command codes, register indexes and character constants for
// the text window terminal core.
// ----------------------------------------------------------------------------
package twt_pkg;

    // Default screen geometry in character cells.
    localparam int SCREEN_COLS_DEF = 80;
    localparam int SCREEN_ROWS_DEF = 25;

    // Field widths.
    localparam int CMD_W    = 3;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int COL_W    = 7;
    localparam int ROW_W    = 5;
    localparam int HW_POS_W = 11;
    localparam int CELL_W   = CHAR_W + ATTR_W;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PRINT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

    // Configuration register indexes (word address bits).
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_FIRST_COL     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FIRST_ROW     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CURSOR_ENABLE = 3'd4;

    // Character codes with a special meaning.
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;

    // One command item.
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [CHAR_W-1:0] character;
        logic [ATTR_W-1:0] attribute;
        logic [COL_W-1:0]  pos_x;
        logic [ROW_W-1:0]  pos_y;
    } cmd_item_t;

    // One result item.
    typedef struct packed {
        logic [CHAR_W-1:0]   read_char;
        logic [ATTR_W-1:0]   read_attr;
        logic [COL_W-1:0]    cursor_x;
        logic [ROW_W-1:0]    cursor_y;
        logic [HW_POS_W-1:0] hw_cursor_pos;
        logic                hw_cursor_changed;
    } rsp_item_t;

endpackage

// ----- design/text_window_terminal_core.sv -----
// ----------------------------------------------------------------------------
// Text window terminal core
// Character cell memory with a configurable window, a software cursor, a
// hardware cursor position, scrolling, clearing and cell access commands.
//
// Channel   Direction  Handshake             Payload
// cmd       in         cmd_valid/cmd_ready   cmd_item_t
// rsp       out        rsp_valid/rsp_ready   rsp_item_t
// apb       in/out     psel/penable/pready   paddr, pwdata, prdata
//
// Print and set cursor run ST_CMD, ST_ACCESS, ST_HW; write cell ST_CMD, ST_ACCESS;
// read cell ST_CMD, ST_ACCESS, ST_READ_WAIT. Each ends in ST_DONE, after which the
// core returns to ST_IDLE for the next command. Clear walks each window cell through
// ST_FILL_ADDR, ST_FILL_WR; a scroll adds ST_SCR_SRC, ST_SCR_RD, ST_SCR_WR per cell.
// Command cell accesses share the one address unit. After reset, a sweep zeroes all
// SCREEN_COLS*SCREEN_ROWS cells (2000 by default) before the first command is taken.
// A finished result waits in the output register while the next command
// is accepted; a stalled result only holds the core at its final step.
// ----------------------------------------------------------------------------
module text_window_terminal_core #(
    parameter int SCREEN_COLS = twt_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = twt_pkg::SCREEN_ROWS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // Command channel
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  twt_pkg::cmd_item_t cmd,
    // Result channel
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output twt_pkg::rsp_item_t rsp,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    import twt_pkg::*;

    localparam int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS;
    localparam int RAM_AW     = $clog2(CELL_COUNT);
    localparam int CALC_W0    = $clog2((SCREEN_ROWS + 63) * SCREEN_COLS + 256);
    localparam int CALC_W     = (CALC_W0 < HW_POS_W) ? HW_POS_W : CALC_W0;

    // Sequencer states.
    localparam logic [3:0] ST_INIT      = 4'd0;
    localparam logic [3:0] ST_IDLE      = 4'd1;
    localparam logic [3:0] ST_CMD       = 4'd2;
    localparam logic [3:0] ST_ACCESS    = 4'd3;
    localparam logic [3:0] ST_READ_WAIT = 4'd4;
    localparam logic [3:0] ST_HW        = 4'd5;
    localparam logic [3:0] ST_SCR_SRC   = 4'd6;
    localparam logic [3:0] ST_SCR_RD    = 4'd7;
    localparam logic [3:0] ST_SCR_WR    = 4'd8;
    localparam logic [3:0] ST_FILL_ADDR = 4'd9;
    localparam logic [3:0] ST_FILL_WR   = 4'd10;
    localparam logic [3:0] ST_DONE      = 4'd11;

    // Control registers.
    logic [3:0]          state_reg, state_next;
    logic [RAM_AW-1:0]   init_cnt_reg, init_cnt_next;
    logic [COL_W-1:0]    cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic [HW_POS_W-1:0] hw_cursor_reg, hw_cursor_next;
    logic [COL_W-1:0]    sc_x_reg, sc_x_next;
    logic [ROW_W-1:0]    sc_y_reg, sc_y_next;
    logic                rsp_valid_reg, rsp_valid_next;

    // Configuration registers.
    logic [COL_W-1:0]    first_col_reg;
    logic [ROW_W-1:0]    first_row_reg;
    logic [COL_W-1:0]    window_width_reg;
    logic [ROW_W-1:0]    window_height_reg;
    logic                cursor_enable_reg;

    // Payload registers.
    cmd_item_t           cmd_reg, cmd_next;
    logic [COL_W-1:0]    tgt_x_reg, tgt_x_next;
    logic [ROW_W-1:0]    tgt_y_reg, tgt_y_next;
    logic                hw_we_reg, hw_we_next;
    logic                scroll_reg, scroll_next;
    logic                src_oob_reg, src_oob_next;
    logic [CHAR_W-1:0]   rc_reg, rc_next;
    logic [ATTR_W-1:0]   ra_reg, ra_next;
    rsp_item_t           rsp_reg, rsp_next;
    logic [CALC_W-1:0]   addr_reg;
    logic                oob_reg;

    // Shared address unit.
    logic [COL_W-1:0]    unit_x;
    logic [ROW_W-1:0]    unit_y;
    logic [ROW_W:0]      row_sum;
    logic [CALC_W-1:0]   unit_addr;
    logic                unit_oob;

    // Window geometry and cursor arithmetic.
    logic [COL_W-1:0]    w_eff;
    logic [ROW_W-1:0]    h_eff;
    logic [COL_W:0]      next_x;
    logic [ROW_W:0]      next_y;
    logic                is_newline;
    logic                sc_last_col;
    logic                sc_last_row;

    // Memory port.
    logic                ram_we;
    logic [RAM_AW-1:0]   ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [CELL_W-1:0]   ram_rdata;
    logic [CELL_W-1:0]   src_data;

    logic                cfg_write;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_col_reg     <= '0;
            first_row_reg     <= '0;
            window_width_reg  <= COL_W'(80);
            window_height_reg <= ROW_W'(25);
            cursor_enable_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:2])
                REG_FIRST_COL:     first_col_reg     <= pwdata[COL_W-1:0];
                REG_FIRST_ROW:     first_row_reg     <= pwdata[ROW_W-1:0];
                REG_WINDOW_WIDTH:  window_width_reg  <= pwdata[COL_W-1:0];
                REG_WINDOW_HEIGHT: window_height_reg <= pwdata[ROW_W-1:0];
                REG_CURSOR_ENABLE: cursor_enable_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (paddr[4:2])
            REG_FIRST_COL:     prdata = 32'(first_col_reg);
            REG_FIRST_ROW:     prdata = 32'(first_row_reg);
            REG_WINDOW_WIDTH:  prdata = 32'(window_width_reg);
            REG_WINDOW_HEIGHT: prdata = 32'(window_height_reg);
            REG_CURSOR_ENABLE: prdata = 32'(cursor_enable_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Window geometry; a zero size acts as one.
    // ------------------------------------------------------------------
    assign w_eff = (window_width_reg == '0) ? COL_W'(1) : window_width_reg;
    assign h_eff = (window_height_reg == '0) ? ROW_W'(1) : window_height_reg;

    assign sc_last_col = (sc_x_reg == w_eff - COL_W'(1));
    assign sc_last_row = (sc_y_reg == h_eff - ROW_W'(1));

    // Cursor candidates for a print command, before truncation.
    assign is_newline = (cmd_reg.character == CHAR_NEWLINE);
    assign next_x     = {1'b0, cur_col_reg} + (COL_W+1)'(1);
    assign next_y     = {1'b0, cur_row_reg} + (ROW_W+1)'(1);

    // ------------------------------------------------------------------
    // Shared address unit: operand select, then one multiply by the row
    // pitch, an add and a range compare, registered.
    // ------------------------------------------------------------------
    always_comb
    begin
        unique case (state_reg)
            ST_CMD:
            begin
                if (cmd_reg.command == CMD_PRINT)
                begin
                    unit_x = cur_col_reg;
                    unit_y = cur_row_reg;
                end
                else
                begin
                    unit_x = cmd_reg.pos_x;
                    unit_y = cmd_reg.pos_y;
                end
            end
            ST_ACCESS:
            begin
                unit_x = tgt_x_reg;
                unit_y = tgt_y_reg;
            end
            ST_SCR_SRC:
            begin
                unit_x = sc_x_reg;
                unit_y = sc_last_row ? sc_y_reg : sc_y_reg + ROW_W'(1);
            end
            default:
            begin
                unit_x = sc_x_reg;
                unit_y = sc_y_reg;
            end
        endcase
    end

    assign row_sum   = {1'b0, first_row_reg} + {1'b0, unit_y};
    assign unit_addr = CALC_W'(row_sum) * CALC_W'(SCREEN_COLS)
                     + CALC_W'(first_col_reg) + CALC_W'(unit_x);
    assign unit_oob  = (unit_addr >= CALC_W'(CELL_COUNT));

    always_ff @(posedge clk)
    begin
        addr_reg <= unit_addr;
        oob_reg  <= unit_oob;
    end

    // ------------------------------------------------------------------
    // Text memory
    // ------------------------------------------------------------------
    assign src_data = src_oob_reg ? '0 : ram_rdata;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = addr_reg[RAM_AW-1:0];
        ram_wdata = {cmd_reg.attribute, cmd_reg.character};
        unique case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = init_cnt_reg;
                ram_wdata = '0;
            end
            ST_ACCESS:
            begin
                ram_we = !oob_reg
                      && (((cmd_reg.command == CMD_PRINT) && !is_newline)
                          || (cmd_reg.command == CMD_WRITE));
                ram_re = !oob_reg && (cmd_reg.command == CMD_READ);
            end
            ST_SCR_RD:
            begin
                ram_re = !oob_reg;
            end
            ST_SCR_WR:
            begin
                ram_we    = !oob_reg;
                ram_wdata = sc_last_row ? {src_data[CELL_W-1:CHAR_W], CHAR_SPACE}
                                        : src_data;
            end
            ST_FILL_WR:
            begin
                ram_we    = !oob_reg;
                ram_wdata = {cmd_reg.attribute, CHAR_SPACE};
            end
            default: ;
        endcase
    end

    twt_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_text_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr_reg[RAM_AW-1:0]),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        init_cnt_next  = init_cnt_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        hw_cursor_next = hw_cursor_reg;
        sc_x_next      = sc_x_reg;
        sc_y_next      = sc_y_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd_next       = cmd_reg;
        tgt_x_next     = tgt_x_reg;
        tgt_y_next     = tgt_y_reg;
        hw_we_next     = hw_we_reg;
        scroll_next    = scroll_reg;
        src_oob_next   = src_oob_reg;
        rc_next        = rc_reg;
        ra_next        = ra_reg;
        rsp_next       = rsp_reg;

        unique case (state_reg)
            // Zero the memory, one cell per cycle.
            ST_INIT:
            begin
                init_cnt_next = init_cnt_reg + RAM_AW'(1);
                if (init_cnt_reg == RAM_AW'(CELL_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    state_next = ST_CMD;
                end
            end

            // Decode and work out where the cursor ends up.
            ST_CMD:
            begin
                rc_next     = '0;
                ra_next     = '0;
                hw_we_next  = 1'b0;
                scroll_next = 1'b0;
                sc_x_next   = '0;
                sc_y_next   = '0;
                case (cmd_reg.command) inside
                    CMD_PRINT:
                    begin
                        hw_we_next = cursor_enable_reg;
                        state_next = ST_ACCESS;
                        if (!is_newline && (next_x < {1'b0, w_eff}))
                        begin
                            tgt_x_next = next_x[COL_W-1:0];
                            tgt_y_next = cur_row_reg;
                        end
                        else if (next_y >= {1'b0, h_eff})
                        begin
                            tgt_x_next  = '0;
                            tgt_y_next  = h_eff - ROW_W'(1);
                            scroll_next = 1'b1;
                        end
                        else
                        begin
                            tgt_x_next = '0;
                            tgt_y_next = next_y[ROW_W-1:0];
                        end
                    end
                    CMD_SET:
                    begin
                        tgt_x_next = cmd_reg.pos_x;
                        tgt_y_next = cmd_reg.pos_y;
                        hw_we_next = cursor_enable_reg && (cmd_reg.pos_x < w_eff);
                        state_next = ST_ACCESS;
                    end
                    CMD_WRITE, CMD_READ:
                    begin
                        state_next = ST_ACCESS;
                    end
                    CMD_CLEAR:
                    begin
                        state_next = ST_FILL_ADDR;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            // Cell write or read issue; the unit now forms the cursor address.
            ST_ACCESS:
            begin
                src_oob_next = oob_reg;
                case (cmd_reg.command) inside
                    CMD_READ:           state_next = ST_READ_WAIT;
                    CMD_PRINT, CMD_SET: state_next = ST_HW;
                    default:            state_next = ST_DONE;
                endcase
            end

            ST_READ_WAIT:
            begin
                rc_next    = src_data[CHAR_W-1:0];
                ra_next    = src_data[CELL_W-1:CHAR_W];
                state_next = ST_DONE;
            end

            // Commit the cursor move.
            ST_HW:
            begin
                cur_col_next = tgt_x_reg;
                cur_row_next = tgt_y_reg;
                if (hw_we_reg)
                begin
                    hw_cursor_next = addr_reg[HW_POS_W-1:0];
                end
                state_next = scroll_reg ? ST_SCR_SRC : ST_DONE;
            end

            // Scroll: source address, read, then write one cell.
            ST_SCR_SRC:
            begin
                state_next = ST_SCR_RD;
            end

            ST_SCR_RD:
            begin
                src_oob_next = oob_reg;
                state_next   = ST_SCR_WR;
            end

            ST_SCR_WR:
            begin
                state_next = ST_SCR_SRC;
                if (sc_last_col)
                begin
                    sc_x_next = '0;
                    sc_y_next = sc_y_reg + ROW_W'(1);
                    if (sc_last_row)
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    sc_x_next = sc_x_reg + COL_W'(1);
                end
            end

            // Clear: address, then write one cell.
            ST_FILL_ADDR:
            begin
                state_next = ST_FILL_WR;
            end

            ST_FILL_WR:
            begin
                state_next = ST_FILL_ADDR;
                if (sc_last_col)
                begin
                    sc_x_next = '0;
                    sc_y_next = sc_y_reg + ROW_W'(1);
                    if (sc_last_row)
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    sc_x_next = sc_x_reg + COL_W'(1);
                end
            end

            // Hand the result to the output register once it is free.
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.read_char         = rc_reg;
                    rsp_next.read_attr         = ra_reg;
                    rsp_next.cursor_x          = cur_col_reg;
                    rsp_next.cursor_y          = cur_row_reg;
                    rsp_next.hw_cursor_pos     = hw_cursor_reg;
                    rsp_next.hw_cursor_changed = hw_we_reg;
                    rsp_valid_next             = 1'b1;
                    state_next                 = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_cnt_reg  <= '0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            hw_cursor_reg <= '0;
            sc_x_reg      <= '0;
            sc_y_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_cnt_reg  <= init_cnt_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            hw_cursor_reg <= hw_cursor_next;
            sc_x_reg      <= sc_x_next;
            sc_y_reg      <= sc_y_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload state.
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        tgt_x_reg   <= tgt_x_next;
        tgt_y_reg   <= tgt_y_next;
        hw_we_reg   <= hw_we_next;
        scroll_reg  <= scroll_next;
        src_oob_reg <= src_oob_next;
        rc_reg      <= rc_next;
        ra_reg      <= ra_next;
        rsp_reg     <= rsp_next;
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The walk counters stay inside the window while scrolling or clearing.
    a_walk_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCR_SRC) || (state_reg == ST_SCR_RD) ||
         (state_reg == ST_SCR_WR) || (state_reg == ST_FILL_ADDR) ||
         (state_reg == ST_FILL_WR))
        |-> ((sc_x_reg < w_eff) && (sc_y_reg < h_eff)))
        else $error("walk counter left the window");

    // A scroll always runs with the cursor parked at column zero of the bottom row.
    a_scroll_cursor_row: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCR_SRC) || (state_reg == ST_SCR_WR))
        |-> ((cur_row_reg == h_eff - ROW_W'(1)) && (cur_col_reg == '0)))
        else $error("scroll with cursor off the bottom row");

    // The hardware cursor moves only when a cursor move commits.
    a_hw_cursor_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_HW) |=> (hw_cursor_reg == $past(hw_cursor_reg)))
        else $error("hardware cursor changed outside a cursor commit");

    // A new result appears only from the final step of a command.
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside the final step");

    // The memory is written only by the sweep or a cell step.
    a_ram_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == ST_INIT) || (state_reg == ST_ACCESS) ||
                    (state_reg == ST_SCR_WR) || (state_reg == ST_FILL_WR)))
        else $error("memory written outside a cell step");

endmodule

// ----- design/twt_ram.sv -----
// ----------------------------------------------------------------------------
// Text window terminal RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module twt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
